### hw/rtl/fpc_pkg.sv
`default_nettype none

package fpc_pkg;

    // widths of the frame path and of the configuration port
    localparam int FRAME_BITS    = 16;
    localparam int INTERVAL_BITS = 10;
    localparam int PBI_BITS      = 12;
    localparam int PROG_BITS     = 26;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int KIND_BITS     = 4;

    // reset values
    localparam logic [INTERVAL_BITS-1:0] FRAME_INTERVAL_RESET = INTERVAL_BITS'(33);
    localparam logic [PBI_BITS-1:0]      PBI_RESET            = PBI_BITS'(33);

    typedef logic [FRAME_BITS-1:0] frame_t;

    // event codes
    typedef enum logic [KIND_BITS-1:0] {
        KIND_TICK    = 4'd0,
        KIND_START   = 4'd1,
        KIND_PAUSE   = 4'd2,
        KIND_SEEK    = 4'd3,
        KIND_NEXT    = 4'd4,
        KIND_PREV    = 4'd5,
        KIND_SPEED   = 4'd6,
        KIND_REFRESH = 4'd7,
        KIND_QUERY   = 4'd8
    } kind_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_INTERVAL = 3'd0,
        REG_BUFFER_MIN     = 3'd1,
        REG_BUFFER_MAX     = 3'd2,
        REG_START_FRAME    = 3'd3,
        REG_END_FRAME      = 3'd4,
        REG_LOOPING        = 3'd5,
        REG_SPEED_MODE     = 3'd6
    } reg_idx_t;

    // speed modes
    typedef enum logic [1:0] {
        SPEED_NORMAL  = 2'd0,
        SPEED_HALF    = 2'd1,
        SPEED_QUARTER = 2'd2
    } speed_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] frame_interval_ms;
        frame_t                   buffer_min_frame;
        frame_t                   buffer_max_frame;
        frame_t                   start_frame;
        frame_t                   end_frame;
        logic                     looping;
        logic [1:0]               speed_mode;
    } cfg_t;

    typedef struct packed {
        frame_t              current_frame;
        frame_t              fence_start_latched;
        frame_t              fence_end_latched;
        frame_t              min_frame_latched;
        logic [PBI_BITS-1:0] playback_interval;
        logic [PBI_BITS-1:0] countdown_ms;
        logic                run_flag;
    } state_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        frame_t               seek_frame;
        logic                 report_on_seek;
    } evt_t;

    typedef struct packed {
        logic                 show_valid;
        frame_t               shown_frame;
        logic                 progress_valid;
        logic [PROG_BITS-1:0] progress_ms;
        logic                 position_valid;
        frame_t               position_frames;
        logic                 stopped_at_end;
        logic                 playing;
    } res_t;

    // min bound first, then max bound (max wins if the bounds cross)
    function automatic frame_t clamp_frame(frame_t f, frame_t mn, frame_t mx);
        frame_t r;
        r = (f < mn) ? mn : f;
        r = (r > mx) ? mx : r;
        return r;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fpc_if.sv
`default_nettype none

// event channel
interface fpc_evt_if;
    logic                     valid;
    logic                     ready;
    logic [3:0]               kind;
    logic [15:0]              seek_frame;
    logic                     report_on_seek;

    modport source (output valid, kind, seek_frame, report_on_seek, input ready);
    modport sink   (input valid, kind, seek_frame, report_on_seek, output ready);
endinterface

// result channel
interface fpc_res_if;
    logic                     valid;
    logic                     ready;
    logic                     show_valid;
    logic [15:0]              shown_frame;
    logic                     progress_valid;
    logic [25:0]              progress_ms;
    logic                     position_valid;
    logic [15:0]              position_frames;
    logic                     stopped_at_end;
    logic                     playing;

    modport source (output valid, show_valid, shown_frame, progress_valid, progress_ms,
                    position_valid, position_frames, stopped_at_end, playing,
                    input ready);
    modport sink   (input valid, show_valid, shown_frame, progress_valid, progress_ms,
                    position_valid, position_frames, stopped_at_end, playing,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/fpc_step.sv
`default_nettype none

module fpc_step
    import fpc_pkg::*;
(
    input  wire cfg_t   cfg,
    input  wire state_t state,
    input  wire evt_t   evt,
    output state_t      state_next,
    output res_t        res
);

    logic [FRAME_BITS:0]   inc_frame;
    frame_t                start_clamped;
    frame_t                end_clamped;
    frame_t                tick_frame;
    frame_t                prog_diff;
    logic                  prog_en;
    logic [PBI_BITS-1:0]   pbi_sel;

    // common clamps and increments
    assign inc_frame     = {1'b0, state.current_frame} + {{FRAME_BITS{1'b0}}, 1'b1};
    assign start_clamped = clamp_frame(cfg.start_frame, cfg.buffer_min_frame,
                                       cfg.buffer_max_frame);
    assign end_clamped   = clamp_frame(cfg.end_frame, cfg.buffer_min_frame,
                                       cfg.buffer_max_frame);

    // wrap or stop past the fence end
    always_comb
    begin
        if (inc_frame > {1'b0, state.fence_end_latched})
        begin
            tick_frame = cfg.looping ? start_clamped : end_clamped;
        end
        else
        begin
            tick_frame = inc_frame[FRAME_BITS-1:0];
        end
    end

    // interval chosen by the speed mode
    always_comb
    begin
        case (cfg.speed_mode)
            SPEED_NORMAL:  pbi_sel = {2'b00, cfg.frame_interval_ms};
            SPEED_HALF:    pbi_sel = {1'b0, cfg.frame_interval_ms, 1'b0};
            SPEED_QUARTER: pbi_sel = {cfg.frame_interval_ms, 2'b00};
            default:       pbi_sel = state.playback_interval;
        endcase
    end

    // event decode and state update
    always_comb
    begin
        state_next          = state;
        prog_en             = 1'b0;
        res                 = '0;
        unique case (evt.kind)
            KIND_TICK:
            begin
                if (state.run_flag)
                begin
                    if (state.countdown_ms > PBI_BITS'(1))
                    begin
                        state_next.countdown_ms = state.countdown_ms - PBI_BITS'(1);
                    end
                    else
                    begin
                        res.show_valid           = 1'b1;
                        res.shown_frame          = state.current_frame;
                        state_next.current_frame = tick_frame;
                        prog_en                  = 1'b1;
                        if ((inc_frame > {1'b0, state.fence_end_latched}) && !cfg.looping)
                        begin
                            res.stopped_at_end  = 1'b1;
                            state_next.run_flag = 1'b0;
                        end
                        else
                        begin
                            state_next.countdown_ms = state.playback_interval;
                        end
                    end
                end
            end
            KIND_START:
            begin
                state_next.run_flag     = 1'b1;
                state_next.countdown_ms = state.playback_interval;
                if (state.current_frame >= state.fence_end_latched)
                begin
                    state_next.current_frame = start_clamped;
                    prog_en                  = 1'b1;
                end
            end
            KIND_PAUSE:
            begin
                state_next.run_flag = 1'b0;
            end
            KIND_SEEK:
            begin
                state_next.current_frame = clamp_frame(evt.seek_frame, cfg.buffer_min_frame,
                                                       cfg.buffer_max_frame);
                res.show_valid           = 1'b1;
                res.shown_frame          = state_next.current_frame;
                prog_en                  = evt.report_on_seek;
            end
            KIND_NEXT:
            begin
                if (!state.run_flag && (state.current_frame < state.fence_end_latched))
                begin
                    state_next.current_frame = inc_frame[FRAME_BITS-1:0];
                    res.show_valid           = 1'b1;
                    res.shown_frame          = inc_frame[FRAME_BITS-1:0];
                    prog_en                  = 1'b1;
                end
            end
            KIND_PREV:
            begin
                if (!state.run_flag && (state.current_frame > state.fence_start_latched))
                begin
                    state_next.current_frame = state.current_frame - FRAME_BITS'(1);
                    res.show_valid           = 1'b1;
                    res.shown_frame          = state.current_frame - FRAME_BITS'(1);
                    prog_en                  = 1'b1;
                end
            end
            KIND_SPEED:
            begin
                state_next.playback_interval = pbi_sel;
                if (state.run_flag)
                begin
                    state_next.countdown_ms = pbi_sel;
                end
            end
            KIND_REFRESH:
            begin
                state_next.playback_interval   = {2'b00, cfg.frame_interval_ms};
                state_next.min_frame_latched   = cfg.buffer_min_frame;
                state_next.fence_start_latched = start_clamped;
                state_next.fence_end_latched   = end_clamped;
                state_next.current_frame       = end_clamped;
                prog_en                        = 1'b1;
            end
            KIND_QUERY:
            begin
                res.position_valid  = 1'b1;
                res.position_frames = state.current_frame - state.min_frame_latched;
            end
            default:
            begin
            end
        endcase

        // progress on the frame left by this word
        prog_diff          = state_next.current_frame - state_next.min_frame_latched;
        res.progress_valid = prog_en;
        if (prog_en)
        begin
            res.progress_ms = {{INTERVAL_BITS{1'b0}}, prog_diff}
                              * {{FRAME_BITS{1'b0}}, cfg.frame_interval_ms};
        end
        res.playing = state_next.run_flag;
    end

endmodule

`default_nettype wire

### hw/rtl/frame_playback_controller_core.sv
// channel   dir  handshake     payload
// evt       in   valid/ready   kind, seek_frame, report_on_seek
// res       out  valid/ready   show/progress/position reports, stopped_at_end, playing
// cfg       in   cfg_we only   cfg_index selects register, cfg_data carries value
//
// every event word gives exactly one result word, through the input register and then the result register
// one event word accepted per cycle unless a stalled result fills the pipe; the input register and
// the result register each hold one word, so a stalled result holds the pipe without losing words
// rst_n empties the pipe and returns the player state and configuration to reset values
// the player state is updated as a word moves from the input to the result register
`default_nettype none

module frame_playback_controller_core
    import fpc_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    fpc_evt_if.sink                   evt,
    fpc_res_if.source                 res,
    input  wire                       cfg_we,
    input  wire [CFG_IDX_BITS-1:0]    cfg_index,
    input  wire [CFG_DATA_BITS-1:0]   cfg_data
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    evt_t   s1_evt_reg;
    logic   s1_valid_reg;
    res_t   out_reg;
    res_t   res_next;
    logic   out_valid_reg;
    logic   advance;
    logic   evt_accept;

    // pipe control
    assign advance    = s1_valid_reg && (!out_valid_reg || res.ready);
    assign evt.ready  = !s1_valid_reg || advance;
    assign evt_accept = evt.valid && evt.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_interval_ms <= FRAME_INTERVAL_RESET;
            cfg_reg.buffer_min_frame  <= '0;
            cfg_reg.buffer_max_frame  <= '0;
            cfg_reg.start_frame       <= '0;
            cfg_reg.end_frame         <= '0;
            cfg_reg.looping           <= 1'b1;
            cfg_reg.speed_mode        <= SPEED_NORMAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_INTERVAL: cfg_reg.frame_interval_ms <= cfg_data[INTERVAL_BITS-1:0];
                REG_BUFFER_MIN:     cfg_reg.buffer_min_frame  <= cfg_data[FRAME_BITS-1:0];
                REG_BUFFER_MAX:     cfg_reg.buffer_max_frame  <= cfg_data[FRAME_BITS-1:0];
                REG_START_FRAME:    cfg_reg.start_frame       <= cfg_data[FRAME_BITS-1:0];
                REG_END_FRAME:      cfg_reg.end_frame         <= cfg_data[FRAME_BITS-1:0];
                REG_LOOPING:        cfg_reg.looping           <= cfg_data[0];
                REG_SPEED_MODE:     cfg_reg.speed_mode        <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            s1_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            s1_evt_reg.kind           <= evt.kind;
            s1_evt_reg.seek_frame     <= evt.seek_frame;
            s1_evt_reg.report_on_seek <= evt.report_on_seek;
        end
    end

    // event decode and next player state
    fpc_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .evt        (s1_evt_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // player state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.current_frame       <= '0;
            state_reg.fence_start_latched <= '0;
            state_reg.fence_end_latched   <= '0;
            state_reg.min_frame_latched   <= '0;
            state_reg.playback_interval   <= PBI_RESET;
            state_reg.countdown_ms        <= '0;
            state_reg.run_flag            <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    // result channel
    assign res.valid           = out_valid_reg;
    assign res.show_valid      = out_reg.show_valid;
    assign res.shown_frame     = out_reg.shown_frame;
    assign res.progress_valid  = out_reg.progress_valid;
    assign res.progress_ms     = out_reg.progress_ms;
    assign res.position_valid  = out_reg.position_valid;
    assign res.position_frames = out_reg.position_frames;
    assign res.stopped_at_end  = out_reg.stopped_at_end;
    assign res.playing         = out_reg.playing;

    // a stop at the fence end always leaves the player paused
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stopped_at_end) |-> !out_reg.playing)
        else $error("stopped_at_end reported while playing");

    // a position answer never carries a frame report
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.position_valid) |->
            (!out_reg.show_valid && !out_reg.progress_valid))
        else $error("position answer mixed with frame report");

    // an accepted word is held in the input register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_accept |=> s1_valid_reg)
        else $error("accepted event word lost");

    // the reported playing flag follows the player state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_reg.playing == state_reg.run_flag))
        else $error("playing flag out of step with player state");

endmodule

`default_nettype wire

### test/tb_frame_playback_controller_core.sv
`default_nettype none

module tb_frame_playback_controller_core;
    import fpc_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_WORDS  = 850;
    localparam int SETTLE_CYCLES = 6;
    localparam int PRINT_CAP     = 100;

    // event codes the block does not know
    localparam logic [KIND_BITS-1:0] KIND_UNUSED_LO = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED_HI = 4'd15;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_BURSTY
    } stall_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fpc_evt_if evt_bus ();
    fpc_res_if res_bus ();

    // driven copies, known from time zero
    logic                     src_valid  = 1'b0;
    evt_t                     src_word   = '0;
    logic                     sink_ready = 1'b0;
    logic                     cfg_we     = 1'b0;
    reg_idx_t                 cfg_index  = REG_FRAME_INTERVAL;
    logic [CFG_DATA_BITS-1:0] cfg_data   = '0;

    assign evt_bus.valid          = src_valid;
    assign evt_bus.kind           = src_word.kind;
    assign evt_bus.seek_frame     = src_word.seek_frame;
    assign evt_bus.report_on_seek = src_word.report_on_seek;
    assign res_bus.ready          = sink_ready;

    frame_playback_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // player configuration as last written
    logic [INTERVAL_BITS-1:0] frame_ms        = FRAME_INTERVAL_RESET;
    frame_t                   buf_lo          = '0;
    frame_t                   buf_hi          = '0;
    frame_t                   fence_start_cfg = '0;
    frame_t                   fence_end_cfg   = '0;
    logic                     loop_on         = 1'b1;
    logic [1:0]               speed_sel       = 2'd0;

    // player state
    frame_t              cur_frame     = '0;
    frame_t              fence_lo      = '0;
    frame_t              fence_hi      = '0;
    frame_t              min_lat       = '0;
    logic [PBI_BITS-1:0] play_interval = PBI_RESET;
    logic [PBI_BITS-1:0] count_ms      = '0;
    logic                running       = 1'b0;

    evt_t pending_q[$];
    res_t expected_q[$];
    int   errors = 0;
    int   quiet  = 0;

    // min bound first, max bound last
    function automatic frame_t limit_to_buffer(frame_t f);
        frame_t r;
        r = (f < buf_lo) ? buf_lo : f;
        if (r > buf_hi)
        begin
            r = buf_hi;
        end
        return r;
    endfunction

    function automatic logic [PROG_BITS-1:0] elapsed_ms(frame_t f);
        frame_t      d;
        logic [31:0] p;
        d = f - min_lat;
        p = 32'(d) * 32'(frame_ms);
        return p[PROG_BITS-1:0];
    endfunction

    // advance the player by one event word and return the report it gives
    function automatic res_t play_event(evt_t w);
        res_t                r;
        logic [FRAME_BITS:0] nxt;
        r = '0;
        case (w.kind)
            KIND_TICK:
            begin
                if (running && count_ms > 1)
                begin
                    count_ms = count_ms - 1'b1;
                end
                else if (running)
                begin
                    r.show_valid  = 1'b1;
                    r.shown_frame = cur_frame;
                    nxt = {1'b0, cur_frame} + 1'b1;
                    if (nxt > {1'b0, fence_hi})
                    begin
                        nxt = {1'b0, limit_to_buffer(fence_start_cfg)};
                        if (!loop_on)
                        begin
                            nxt = {1'b0, limit_to_buffer(fence_end_cfg)};
                            r.stopped_at_end = 1'b1;
                            running = 1'b0;
                        end
                    end
                    cur_frame = nxt[FRAME_BITS-1:0];
                    if (running)
                    begin
                        count_ms = play_interval;
                    end
                    r.progress_valid = 1'b1;
                    r.progress_ms    = elapsed_ms(cur_frame);
                end
            end
            KIND_START:
            begin
                running  = 1'b1;
                count_ms = play_interval;
                if (cur_frame >= fence_hi)
                begin
                    cur_frame        = limit_to_buffer(fence_start_cfg);
                    r.progress_valid = 1'b1;
                    r.progress_ms    = elapsed_ms(cur_frame);
                end
            end
            KIND_PAUSE:
            begin
                running = 1'b0;
            end
            KIND_SEEK:
            begin
                cur_frame     = limit_to_buffer(w.seek_frame);
                r.show_valid  = 1'b1;
                r.shown_frame = cur_frame;
                if (w.report_on_seek)
                begin
                    r.progress_valid = 1'b1;
                    r.progress_ms    = elapsed_ms(cur_frame);
                end
            end
            KIND_NEXT, KIND_PREV:
            begin
                // steps only while paused and inside the fence
                if (!running && ((w.kind == KIND_NEXT && cur_frame < fence_hi) ||
                                 (w.kind == KIND_PREV && cur_frame > fence_lo)))
                begin
                    cur_frame = (w.kind == KIND_NEXT) ? cur_frame + 1'b1 : cur_frame - 1'b1;
                    r.show_valid     = 1'b1;
                    r.shown_frame    = cur_frame;
                    r.progress_valid = 1'b1;
                    r.progress_ms    = elapsed_ms(cur_frame);
                end
            end
            KIND_SPEED:
            begin
                case (speed_sel)
                    SPEED_NORMAL:  play_interval = PBI_BITS'(frame_ms);
                    SPEED_HALF:    play_interval = PBI_BITS'(frame_ms) << 1;
                    SPEED_QUARTER: play_interval = PBI_BITS'(frame_ms) << 2;
                    default:       ;
                endcase
                if (running)
                begin
                    count_ms = play_interval;
                end
            end
            KIND_REFRESH:
            begin
                play_interval    = PBI_BITS'(frame_ms);
                min_lat          = buf_lo;
                fence_lo         = limit_to_buffer(fence_start_cfg);
                fence_hi         = limit_to_buffer(fence_end_cfg);
                cur_frame        = fence_hi;
                r.progress_valid = 1'b1;
                r.progress_ms    = elapsed_ms(cur_frame);
            end
            KIND_QUERY:
            begin
                r.position_valid  = 1'b1;
                r.position_frames = cur_frame - min_lat;
            end
            default:
            begin
            end
        endcase
        r.playing = running;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
        errors++;
        if (errors <= PRINT_CAP)
        begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got_v, want_v);
        end
    endtask

    task automatic check_word(res_t got, res_t want);
        if (got.show_valid !== want.show_valid)
            report_mismatch("show_valid", got.show_valid, want.show_valid);
        if (got.shown_frame !== want.shown_frame)
            report_mismatch("shown_frame", got.shown_frame, want.shown_frame);
        if (got.progress_valid !== want.progress_valid)
            report_mismatch("progress_valid", got.progress_valid, want.progress_valid);
        if (got.progress_ms !== want.progress_ms)
            report_mismatch("progress_ms", got.progress_ms, want.progress_ms);
        if (got.position_valid !== want.position_valid)
            report_mismatch("position_valid", got.position_valid, want.position_valid);
        if (got.position_frames !== want.position_frames)
            report_mismatch("position_frames", got.position_frames, want.position_frames);
        if (got.stopped_at_end !== want.stopped_at_end)
            report_mismatch("stopped_at_end", got.stopped_at_end, want.stopped_at_end);
        if (got.playing !== want.playing)
            report_mismatch("playing", got.playing, want.playing);
    endtask

    // one register write, to be made only while the player is idle; the task itself does not enforce it
    task automatic write_register(reg_idx_t idx, int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        case (idx)
            REG_FRAME_INTERVAL: frame_ms        = INTERVAL_BITS'(value);
            REG_BUFFER_MIN:     buf_lo          = frame_t'(value);
            REG_BUFFER_MAX:     buf_hi          = frame_t'(value);
            REG_START_FRAME:    fence_start_cfg = frame_t'(value);
            REG_END_FRAME:      fence_end_cfg   = frame_t'(value);
            REG_LOOPING:        loop_on         = value[0];
            REG_SPEED_MODE:     speed_sel       = value[1:0];
            default:            ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(int unsigned iv, frame_t lo, frame_t hi, frame_t st, frame_t en,
                             logic lp, logic [1:0] sp);
        write_register(REG_FRAME_INTERVAL, iv);
        write_register(REG_BUFFER_MIN, lo);
        write_register(REG_BUFFER_MAX, hi);
        write_register(REG_START_FRAME, st);
        write_register(REG_END_FRAME, en);
        write_register(REG_LOOPING, lp);
        write_register(REG_SPEED_MODE, sp);
    endtask

    function automatic void add_word(logic [KIND_BITS-1:0] k, frame_t f, logic rep);
        evt_t w;
        w.kind           = k;
        w.seek_frame     = f;
        w.report_on_seek = rep;
        pending_q.push_back(w);
    endfunction

    // wait until every word has gone through and the pipe is empty
    task automatic wait_idle;
        while (pending_q.size() > 0 || src_valid || expected_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // event driver: bursts with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            src_valid  <= 1'b0;
            src_word   <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!src_valid || evt_bus.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                src_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                src_word  <= pending_q.pop_front();
                src_valid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern changes every so often
    int     stall_tick = 0;
    stall_t stall_mode = STALL_NONE;

    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            stall_tick = 0;
        end
        else
        begin
            stall_tick++;
            if (stall_tick % 97 == 0)
            begin
                stall_mode = stall_t'($urandom_range(0, 3));
            end
            case (stall_mode)
                STALL_NONE:   sink_ready <= 1'b1;
                STALL_COIN:   sink_ready <= ($urandom_range(0, 1) == 1);
                STALL_SPARSE: sink_ready <= (stall_tick % 4 == 0);
                default:      sink_ready <= (stall_tick % 8 < 5);
            endcase
        end
    end

    // monitor: check results, predict accepted words, watch for a hang
    always @(posedge clk)
    begin : monitor
        res_t got;
        if (rst_n)
        begin
            if (res_bus.valid && sink_ready)
            begin
                got.show_valid      = res_bus.show_valid;
                got.shown_frame     = res_bus.shown_frame;
                got.progress_valid  = res_bus.progress_valid;
                got.progress_ms     = res_bus.progress_ms;
                got.position_valid  = res_bus.position_valid;
                got.position_frames = res_bus.position_frames;
                got.stopped_at_end  = res_bus.stopped_at_end;
                got.playing         = res_bus.playing;
                if (expected_q.size() == 0)
                    report_mismatch("result words waiting", 1, 0);
                else
                    check_word(got, expected_q.pop_front());
            end
            if (src_valid && evt_bus.ready)
            begin
                expected_q.push_back(play_event(src_word));
            end
            if ((res_bus.valid && sink_ready) || (src_valid && evt_bus.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int                    made;
        int                    n;
        int                    pick;
        int unsigned           iv;
        frame_t                lo;
        frame_t                hi;
        frame_t                st;
        frame_t                en;
        logic [KIND_BITS-1:0]  k;
        frame_t                tgt;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short interval, narrow buffer, looping fence 12..14
        write_all(1, 10, 20, 12, 14, 1'b1, SPEED_HALF);
        add_word(KIND_QUERY, '0, 1'b0);
        add_word(KIND_REFRESH, '0, 1'b0);
        add_word(KIND_NEXT, '0, 1'b0);
        add_word(KIND_PREV, '0, 1'b0);
        add_word(KIND_PREV, '0, 1'b0);
        add_word(KIND_START, '0, 1'b0);
        add_word(KIND_NEXT, '0, 1'b0);
        add_word(KIND_TICK, '0, 1'b0);
        add_word(KIND_SPEED, '0, 1'b0);
        repeat (4) add_word(KIND_TICK, '0, 1'b0);
        add_word(KIND_PAUSE, '0, 1'b0);
        add_word(KIND_PREV, '0, 1'b0);
        add_word(KIND_SEEK, 16'd0, 1'b1);
        add_word(KIND_SEEK, 16'hFFFF, 1'b0);
        add_word(KIND_START, '0, 1'b0);
        add_word(KIND_UNUSED_HI, 16'hFFFF, 1'b1);
        wait_idle();

        // zero interval, speed mode three, top of the frame range, no looping
        write_all(0, 16'hFFFD, 16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 2'd3);
        add_word(KIND_REFRESH, '0, 1'b0);
        add_word(KIND_SPEED, '0, 1'b0);
        add_word(KIND_START, '0, 1'b0);
        repeat (4) add_word(KIND_TICK, '0, 1'b0);
        add_word(KIND_QUERY, '0, 1'b0);
        wait_idle();

        // random phases, each with a fresh setting
        made = 0;
        while (made < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       iv = 0;
                1:       iv = 1000;
                2:       iv = 1023;
                3:       iv = $urandom_range(0, 1023);
                default: iv = $urandom_range(1, 4);
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0:
                begin
                    lo = 16'd0;
                    hi = 16'hFFFF;
                end
                1:
                begin
                    hi = 16'hFFFF;
                    lo = hi - frame_t'($urandom_range(0, 12));
                end
                2:
                begin
                    lo = frame_t'($urandom_range(20, 65535));
                    hi = lo - frame_t'($urandom_range(1, 20));
                end
                3:
                begin
                    lo = frame_t'($urandom_range(0, 65535));
                    hi = lo;
                end
                default:
                begin
                    lo = frame_t'($urandom_range(0, 65500));
                    hi = lo + frame_t'($urandom_range(0, 30));
                end
            endcase
            st = frame_t'(int'(lo) + int'($urandom_range(0, 24)) - 2);
            if ($urandom_range(0, 5) == 0)
                st = frame_t'($urandom_range(0, 65535));
            en = st + frame_t'($urandom_range(0, 12));
            if ($urandom_range(0, 4) == 0)
                en = st - frame_t'($urandom_range(1, 5));
            if ($urandom_range(0, 5) == 0)
                en = frame_t'($urandom_range(0, 65535));
            write_all(iv, lo, hi, st, en, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));

            // mostly a latched fence and a running player, then mixed events
            if ($urandom_range(0, 4) != 0)
                add_word(KIND_REFRESH, frame_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
                add_word(KIND_SPEED, frame_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) != 0)
                add_word(KIND_START, frame_t'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
            n = $urandom_range(25, 60);
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                tgt  = frame_t'($urandom_range(0, 65535));
                if (pick < 55)
                    k = KIND_TICK;
                else if (pick < 61)
                    k = KIND_START;
                else if (pick < 64)
                    k = KIND_PAUSE;
                else if (pick < 71)
                begin
                    k = KIND_SEEK;
                    if ($urandom_range(0, 4) < 3)
                        tgt = frame_t'(int'(buf_lo) + int'($urandom_range(0, 30)) - 3);
                end
                else if (pick < 77)
                    k = KIND_NEXT;
                else if (pick < 83)
                    k = KIND_PREV;
                else if (pick < 87)
                    k = KIND_SPEED;
                else if (pick < 90)
                    k = KIND_REFRESH;
                else if (pick < 96)
                    k = KIND_QUERY;
                else
                    k = KIND_BITS'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                add_word(k, tgt, 1'($urandom_range(0, 1)));
            end
            made += n;
            wait_idle();
        end

        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hw/rtl/fpc_pkg.sv
hw/rtl/fpc_if.sv
hw/rtl/fpc_step.sv
hw/rtl/frame_playback_controller_core.sv
test/tb_frame_playback_controller_core.sv
